// ===== rtl/hpp_pkg.sv =====
// Shared types and constants of the height-map pixel picker.
`default_nettype none
package hpp_pkg;

    localparam int MAX_SIDE      = 128;
    localparam int TRI_W         = 64;
    localparam int TRI_H         = 32;
    localparam int HALF_W        = TRI_W / 2;
    localparam int HEIGHT_SCALE  = 5;
    localparam int MAX_ROW_STEPS = 16;

    localparam int IDX_W   = $clog2(MAX_SIDE);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int X_W     = $clog2(MAX_SIDE * TRI_W);
    localparam int Y_W     = $clog2(MAX_SIDE * TRI_H);
    localparam int PIX_W   = 16;
    localparam int HGT_W   = 8;
    localparam int STEP_W  = $clog2(MAX_ROW_STEPS + 1);

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOCATE = 1'b1;

    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [6:0]  node_col;
        logic [6:0]  node_row;
        logic [7:0]  node_height;
    } t_in_item;

    typedef struct packed {
        logic [6:0] near_col;
        logic [6:0] near_row;
        logic [6:0] tri_col;
        logic [6:0] tri_row;
        logic       tri_kind;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_WALK0,
        ST_WALK,
        ST_NEAR1,
        ST_NEAR2,
        ST_NEAR3,
        ST_TLOAD,
        ST_TTEST,
        ST_FIN
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/hpp_mem.sv =====
// Height map storage: one write port, one registered read port.
`default_nettype none
module hpp_mem
    import hpp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [HGT_W-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [HGT_W-1:0]  o_rdata
);

    logic [HGT_W-1:0] r_mem [MAX_SIDE*MAX_SIDE];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/hpp_mod.sv =====
// Iterative remainder unit: wraps both pixel coordinates, one bit a cycle.
`default_nettype none
module hpp_mod
    import hpp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [PIX_W-1:0] i_num_x,
    input  wire logic [PIX_W-1:0] i_num_y,
    input  wire logic [X_W:0]     i_den_x,
    input  wire logic [Y_W:0]     i_den_y,
    output logic                  o_done,
    output logic      [X_W-1:0]   o_rem_x,
    output logic      [Y_W-1:0]   o_rem_y
);

    logic [PIX_W-1:0] r_nx, r_ny;
    logic [X_W:0]     r_rx;
    logic [Y_W:0]     r_ry;
    logic [3:0]       r_cnt;
    logic             r_busy, r_done;
    logic [X_W:0]     w_tx;
    logic [Y_W:0]     w_ty;

    always_comb begin
        w_tx = {r_rx[X_W-1:0], r_nx[PIX_W-1]};
        w_ty = {r_ry[Y_W-1:0], r_ny[PIX_W-1]};
        if (w_tx >= i_den_x) begin
            w_tx = w_tx - i_den_x;
        end
        if (w_ty >= i_den_y) begin
            w_ty = w_ty - i_den_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == 4'(PIX_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(PIX_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nx <= i_num_x;
            r_ny <= i_num_y;
            r_rx <= '0;
            r_ry <= '0;
        end else if (r_busy) begin
            r_nx <= {r_nx[PIX_W-2:0], 1'b0};
            r_ny <= {r_ny[PIX_W-2:0], 1'b0};
            r_rx <= w_tx;
            r_ry <= w_ty;
        end
    end

    assign o_done  = r_done;
    assign o_rem_x = r_rx[X_W-1:0];
    assign o_rem_y = r_ry[Y_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/heightmap_pixel_picker_top.sv =====
// Top level of the height-map pixel picker: sequencer, walk and triangle tests.
//
// Input channel i_valid/o_stall/i_data carries write and locate items; an item
// is taken when i_valid is high and o_stall low. A write stores one node height
// and gives no result. A locate gives one result item on o_valid/i_stall/o_data.
// A locate runs the remainder unit (16 bits, one a cycle, then its done flag),
// the set-up states ST_SETUP and ST_WALK0, one map read per walk step (1 to 17),
// the distance pick in ST_NEAR1 to ST_NEAR3, the triangle reads and tests in
// ST_TLOAD and ST_TTEST and the finish state ST_FIN, then returns to ST_IDLE
// before it takes the next item. The map RAM has one registered read port, and
// every lift read goes through it.
// The block takes one item at a time; o_stall is high while a locate is busy.
// A finished result sits in an output register, so the next item is taken
// while it waits; a further result waits in the sequencer until that register
// is freed. Reset clears control state and sets both size registers to 64;
// the map RAM is not cleared and every node must be written before a locate
// reads it. Sizes must be written over the APB port only while the block is
// idle; the user is bound by this and the block itself does not enforce it.
`default_nettype none
module heightmap_pixel_picker_top
    import hpp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_data,
    input  wire logic      psel,
    input  wire logic      penable,
    input  wire logic      pwrite,
    input  wire logic [2:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] v,
                                                input logic [7:0] n);
        return ((8'(v) + 8'd1) >= n) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] f_prev(input logic [IDX_W-1:0] v,
                                                input logic [7:0] n);
        return (v == '0) ? IDX_W'(n - 8'd1) : v - 1'b1;
    endfunction

    t_state r_state, n_state;

    logic [7:0] r_cfg_w, r_cfg_h, w_w, w_h;
    logic       w_in_acc, w_cfg_wr;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [HGT_W-1:0]  mem_rdata;

    logic             mod_start, mod_done;
    logic [X_W-1:0]   mod_rem_x;
    logic [Y_W-1:0]   mod_rem_y;

    logic [IDX_W-1:0] r_lc, r_rc, r_row, r_nrow, r_near_col, r_near_row;
    logic [IDX_W-1:0] r_tc, r_tr;
    logic             r_tk, r_slash;
    logic [STEP_W-1:0] r_steps;
    logic signed [15:0] r_base, r_lo_dy, r_up_dy, r_ya, r_yb;
    logic signed [33:0] r_sq_up, r_sq_lo;
    logic [1:0]       r_k;
    logic             r_out_valid;
    t_out_item        r_res;

    logic [7:0]       w_col, w_rc_t;
    logic [IDX_W-1:0] w_lc0, w_rc0, w_row0;
    logic             w_slash0;
    logic [4:0]       w_off;
    logic signed [15:0] w_lift, w_ysg, w_new_lo;
    logic             w_adv;
    logic signed [6:0] w_dx_off, w_dx_rest;
    logic signed [33:0] w_sq;
    logic signed [15:0] w_dy;
    logic signed [6:0]  w_dx;
    logic [1:0]       w_ak;
    logic [ADDR_W-1:0] w_taddr;
    logic signed [15:0] w_ldy, w_pdy;
    logic signed [7:0]  w_pdx, w_scale;
    logic signed [23:0] w_lhs, w_rhs;
    logic             w_pass;
    logic [IDX_W-1:0] w_tc, w_tr;
    logic             w_tk;

    // effective sizes
    always_comb begin
        w_w = (r_cfg_w == 8'd0) ? 8'd1 : (r_cfg_w > 8'(MAX_SIDE)) ? 8'(MAX_SIDE) : r_cfg_w;
        w_h = (r_cfg_h == 8'd0) ? 8'd1 : (r_cfg_h > 8'(MAX_SIDE)) ? 8'(MAX_SIDE) : r_cfg_h;
    end

    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_MAP_HEIGHT) ? {24'd0, r_cfg_h} : {24'd0, r_cfg_w};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 8'd64;
            r_cfg_h <= 8'd64;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_MAP_WIDTH) begin
                r_cfg_w <= pwdata[7:0];
            end else begin
                r_cfg_h <= pwdata[7:0];
            end
        end
    end

    hpp_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_data.node_height),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    hpp_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_num_x (i_data.pixel_x),
        .i_num_y (i_data.pixel_y),
        .i_den_x ((X_W+1)'(w_w) * (X_W+1)'(TRI_W)),
        .i_den_y ((Y_W+1)'(w_h) * (Y_W+1)'(TRI_H)),
        .o_done  (mod_done),
        .o_rem_x (mod_rem_x),
        .o_rem_y (mod_rem_y)
    );

    // datapath terms
    always_comb begin
        w_col    = 8'(mod_rem_x / HALF_W);
        w_lc0    = IDX_W'(w_col >> 1);
        w_rc_t   = 8'((9'(w_col) + 9'd1) >> 1);
        w_rc0    = (w_rc_t == w_w) ? '0 : IDX_W'(w_rc_t);
        w_row0   = IDX_W'(mod_rem_y / TRI_H);
        w_slash0 = w_col[0] ^ w_row0[0];
        w_off    = 5'(mod_rem_x % HALF_W);
        w_lift   = signed'(16'(mem_rdata) * 16'(HEIGHT_SCALE));
        w_ysg    = signed'(16'(mod_rem_y));
        w_new_lo = r_base + 16'(TRI_H) - w_lift - w_ysg;
        w_adv    = (w_new_lo < 0) && (r_steps < STEP_W'(MAX_ROW_STEPS));
        w_dx_off  = signed'(7'(w_off));
        w_dx_rest = signed'(7'(HALF_W) - 7'(w_off));
        if (r_state == ST_NEAR1) begin
            w_dy = r_up_dy;
            w_dx = r_slash ? w_dx_rest : w_dx_off;
        end else begin
            w_dy = r_lo_dy;
            w_dx = r_slash ? w_dx_off : w_dx_rest;
        end
        w_sq = 34'(w_dy) * 34'(w_dy) + 34'(w_dx) * 34'(w_dx);
    end

    // triangle read addresses
    always_comb begin
        if (r_state == ST_NEAR3) begin
            w_ak = 2'd0;
        end else if (r_state == ST_TLOAD) begin
            w_ak = 2'd1;
        end else begin
            w_ak = r_k + 2'd1;
        end
        case (w_ak)
            2'd0: w_taddr = r_slash ? {r_row, f_prev(r_rc, w_w)} : {r_row, r_lc};
            2'd1: w_taddr = r_slash ? {r_row, r_rc} : {r_row, f_next(r_lc, w_w)};
            2'd2: w_taddr = r_slash ? {r_nrow, r_lc} : {r_nrow, r_rc};
            2'd3: w_taddr = r_slash ? {r_nrow, f_next(r_lc, w_w)} : {r_nrow, f_prev(r_rc, w_w)};
            default: w_taddr = '0;
        endcase
    end

    // triangle edge test
    always_comb begin
        w_ldy = r_yb - r_ya;
        w_pdy = r_yb - w_ysg;
        case (r_k)
            2'd1: begin
                w_scale = 8'(TRI_W);
                w_pdx   = r_slash ? signed'(8'(HALF_W) - 8'(w_off))
                                  : signed'(8'(TRI_W) - 8'(w_off));
            end
            2'd2: begin
                w_scale = 8'(HALF_W);
                w_pdx   = signed'(8'(HALF_W) - 8'(w_off));
            end
            default: begin
                w_scale = 8'(TRI_W);
                w_pdx   = r_slash ? signed'(8'(TRI_W) - 8'(w_off))
                                  : signed'(8'(HALF_W) - 8'(w_off));
            end
        endcase
        w_lhs  = 24'(w_pdy) * 24'(w_scale);
        w_rhs  = 24'(w_ldy) * 24'(w_pdx);
        w_pass = w_lhs > w_rhs;
        case (r_k)
            2'd1: begin
                w_tc = r_slash ? r_lc : r_rc;
                w_tr = f_prev(r_row, w_h);
                w_tk = 1'b0;
            end
            2'd2: begin
                w_tc = r_slash ? f_prev(r_rc, w_w) : r_lc;
                w_tr = r_row;
                w_tk = 1'b1;
            end
            default: begin
                if (w_pass) begin
                    w_tc = r_slash ? r_rc : r_lc;
                    w_tr = r_row;
                    w_tk = 1'b0;
                end else begin
                    w_tc = r_slash ? r_lc : f_prev(r_rc, w_w);
                    w_tr = r_nrow;
                    w_tk = 1'b1;
                end
            end
        endcase
    end

    assign w_in_acc = i_valid && !o_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_in_acc && i_data.cmd == CMD_LOCATE) n_state = ST_DIV;
            ST_DIV:   if (mod_done) n_state = ST_SETUP;
            ST_SETUP: n_state = ST_WALK0;
            ST_WALK0: n_state = ST_WALK;
            ST_WALK:  if (!w_adv) n_state = ST_NEAR1;
            ST_NEAR1: n_state = ST_NEAR2;
            ST_NEAR2: n_state = ST_NEAR3;
            ST_NEAR3: n_state = ST_TLOAD;
            ST_TLOAD: if (r_k != 2'd0) n_state = ST_TTEST;
            ST_TTEST: n_state = (w_pass || r_k == 2'd3) ? ST_FIN : ST_TLOAD;
            ST_FIN:   if (!r_out_valid || !i_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_stall   = (r_state != ST_IDLE);
        mem_we    = 1'b0;
        mod_start = 1'b0;
        mem_waddr = {i_data.node_row, i_data.node_col};
        mem_raddr = w_taddr;
        case (r_state)
            ST_IDLE: begin
                mem_we    = w_in_acc && (i_data.cmd == CMD_WRITE);
                mod_start = w_in_acc && (i_data.cmd == CMD_LOCATE);
            end
            ST_SETUP: mem_raddr = {w_row0, w_slash0 ? w_rc0 : w_lc0};
            ST_WALK0: mem_raddr = {r_nrow, r_slash ? r_lc : r_rc};
            ST_WALK:  mem_raddr = {f_next(r_nrow, w_h), r_slash ? r_rc : r_lc};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_steps     <= '0;
            r_k         <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_FIN && (!r_out_valid || !i_stall)) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_SETUP: r_steps <= '0;
                ST_WALK:  if (w_adv) r_steps <= r_steps + 1'b1;
                ST_NEAR3: r_k <= 2'd0;
                ST_TLOAD: if (r_k == 2'd0) r_k <= 2'd1;
                ST_TTEST: if (!w_pass && r_k != 2'd3) r_k <= r_k + 2'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_SETUP: begin
                r_lc    <= w_lc0;
                r_rc    <= w_rc0;
                r_row   <= w_row0;
                r_nrow  <= f_next(w_row0, w_h);
                r_slash <= w_slash0;
                r_base  <= signed'(16'(w_row0) * 16'(TRI_H));
            end
            ST_WALK0: r_lo_dy <= r_base - w_lift - w_ysg;
            ST_WALK: begin
                r_base  <= r_base + 16'(TRI_H);
                r_up_dy <= r_lo_dy;
                r_lo_dy <= w_new_lo;
                if (w_adv) begin
                    r_row   <= r_nrow;
                    r_nrow  <= f_next(r_nrow, w_h);
                    r_slash <= !r_slash;
                end
            end
            ST_NEAR1: r_sq_up <= w_sq;
            ST_NEAR2: r_sq_lo <= w_sq;
            ST_NEAR3: begin
                if (r_sq_up < r_sq_lo) begin
                    r_near_col <= r_slash ? r_rc : r_lc;
                    r_near_row <= r_row;
                end else begin
                    r_near_col <= r_slash ? r_lc : r_rc;
                    r_near_row <= r_nrow;
                end
            end
            ST_TLOAD: begin
                case (r_k)
                    2'd0: r_ya <= r_base - 16'(TRI_H) - w_lift;
                    2'd1: r_yb <= r_base - 16'(TRI_H) - w_lift;
                    2'd2: begin
                        if (r_slash) r_ya <= r_base - w_lift;
                        else r_yb <= r_base - w_lift;
                    end
                    default: begin
                        if (r_slash) r_yb <= r_base - w_lift;
                        else r_ya <= r_base - w_lift;
                    end
                endcase
            end
            ST_TTEST: begin
                r_tc <= w_tc;
                r_tr <= w_tr;
                r_tk <= w_tk;
            end
            ST_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    r_res.near_col <= r_near_col;
                    r_res.near_row <= r_near_row;
                    r_res.tri_col  <= r_tc;
                    r_res.tri_row  <= r_tr;
                    r_res.tri_kind <= r_tk;
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_res;

`ifndef SYNTHESIS
    a_steps_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= STEP_W'(MAX_ROW_STEPS))
        else $error("row walk ran past its cap");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_FIN))
        else $error("result raised outside the finish step");

    a_mod_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> r_state == ST_DIV)
        else $error("remainder unit finished while not awaited");

    a_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_state == ST_IDLE)
        else $error("map write started a locate sequence");
`endif

endmodule
`default_nettype wire
